@@ hw/rtl/ccslm_pkg.sv @@
// Package for the crank and cam signal-loss monitor.
// Holds the beat structs, event codes, register indexes and the countdown limit.
// No dependencies.
package ccslm_pkg;

  localparam int unsigned CfgAddrWidth = 4;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned CntWidth     = 8;

  localparam logic [CntWidth-1:0] CntLimit = 8'd250;

  typedef enum logic [1:0] {
    RegStallConfirmTime = 2'd0,
    RegIntakePresent    = 2'd1,
    RegExhaustPresent   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvLoss  = 2'd1,
    EvNosig = 2'd2
  } event_e;

  typedef struct packed {
    logic action;
    logic rotation_detected;
    logic crank_sync;
    logic crank_sync_status;
    logic intake_cam_sync;
    logic intake_cam_sync_status;
    logic exhaust_cam_sync;
    logic exhaust_cam_sync_status;
    logic force_crank_test;
    logic force_intake_test;
    logic force_exhaust_test;
  } ccslm_in_t;

  typedef struct packed {
    logic [1:0] crank_event;
    logic [1:0] intake_event;
    logic [1:0] exhaust_event;
    logic       crank_nosig_enable;
    logic       intake_nosig_enable;
    logic       exhaust_nosig_enable;
  } ccslm_out_t;

endpackage

@@ hw/rtl/ccslm_loss_timer.sv @@
// Joint-loss countdown for one cam of the signal-loss monitor.
// Depends on ccslm_pkg for the counter width.
module ccslm_loss_timer import ccslm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                both_lost_i,
  input  logic [CntWidth-1:0] start_i,
  output logic                timed_out_o
);

  logic                prev_q, prev_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                tmo_q, tmo_d;

  always_comb begin
    cnt_d  = cnt_q;
    tmo_d  = tmo_q;
    prev_d = both_lost_i;
    if (!prev_q && both_lost_i) begin
      cnt_d = start_i;
      tmo_d = (start_i == '0);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CntWidth'(1);
      tmo_d = (cnt_q == CntWidth'(1));
    end
  end

  assign timed_out_o = tmo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b1;
      cnt_q  <= '0;
      tmo_q  <= 1'b0;
    end else if (step_i) begin
      prev_q <= prev_d;
      cnt_q  <= cnt_d;
      tmo_q  <= tmo_d;
    end
  end

endmodule

@@ hw/rtl/crank_cam_signal_loss_monitor.sv @@
// Top level of the crank and cam signal-loss monitor.
// Depends on ccslm_pkg and ccslm_loss_timer.
//
// The sync flags of each accepted non-key-on beat update the two joint-loss
// countdowns and the three sticky no-signal enables; the chosen diagnostic
// events land in the result register at the same edge, shown the cycle after.
// The result register is the only buffer, so one beat can be taken every
// cycle unless a held result is stalled. The user must write configuration
// through the APB port only while idle; the block does not enforce it.
module crank_cam_signal_loss_monitor import ccslm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  ccslm_in_t               in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output ccslm_out_t              out_data_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  output logic [CfgDataWidth-1:0] prdata,
  output logic                    pready
);

  logic [CntWidth-1:0] stall_time_q;
  logic                intake_present_q, exhaust_present_q;
  logic [1:0]          reg_idx;
  logic                cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_time_q      <= '0;
      intake_present_q  <= 1'b1;
      exhaust_present_q <= 1'b1;
    end else if (cfg_we) begin
      case (reg_idx)
        RegStallConfirmTime: stall_time_q      <= pwdata[CntWidth-1:0];
        RegIntakePresent:    intake_present_q  <= pwdata[0];
        RegExhaustPresent:   exhaust_present_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegStallConfirmTime: prdata = {{(CfgDataWidth-CntWidth){1'b0}}, stall_time_q};
      RegIntakePresent:    prdata = {{(CfgDataWidth-1){1'b0}}, intake_present_q};
      RegExhaustPresent:   prdata = {{(CfgDataWidth-1){1'b0}}, exhaust_present_q};
      default:             prdata = '0;
    endcase
  end

  logic       out_valid_q;
  ccslm_out_t out_data_q, out_data_d;
  logic       in_accept, step;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign step        = in_accept && !in_data_i.action;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  logic                ck_ok, ic_ok, ec_ok, in_lost, ex_lost;
  logic [CntWidth-1:0] start_val;
  logic                in_tmo, ex_tmo;

  assign ck_ok     = in_data_i.crank_sync && in_data_i.crank_sync_status;
  assign ic_ok     = in_data_i.intake_cam_sync && in_data_i.intake_cam_sync_status;
  assign ec_ok     = in_data_i.exhaust_cam_sync && in_data_i.exhaust_cam_sync_status;
  assign in_lost   = !ck_ok && !ic_ok;
  assign ex_lost   = !ck_ok && !ec_ok;
  assign start_val = (stall_time_q > CntLimit) ? CntLimit : stall_time_q;

  ccslm_loss_timer u_intake_timer (
    .clk_i,
    .rst_ni,
    .step_i      (step),
    .both_lost_i (in_lost),
    .start_i     (start_val),
    .timed_out_o (in_tmo)
  );

  ccslm_loss_timer u_exhaust_timer (
    .clk_i,
    .rst_ni,
    .step_i      (step),
    .both_lost_i (ex_lost),
    .start_i     (start_val),
    .timed_out_o (ex_tmo)
  );

  logic ck_en_q, ic_en_q, ec_en_q;
  logic ck_en_d, ic_en_d, ec_en_d;

  always_comb begin
    ck_en_d = ck_en_q;
    ic_en_d = ic_en_q;
    ec_en_d = ec_en_q;
    if (in_data_i.action) begin
      ck_en_d = !in_data_i.rotation_detected;
      ic_en_d = !in_data_i.rotation_detected;
      ec_en_d = !in_data_i.rotation_detected;
    end else begin
      if (ck_ok) begin
        ck_en_d = 1'b0;
      end else if (in_tmo && in_lost) begin
        ck_en_d = 1'b1;
      end
      if (ic_ok) begin
        ic_en_d = 1'b0;
      end else if (in_tmo && in_lost) begin
        ic_en_d = 1'b1;
      end
      if (ec_ok) begin
        ec_en_d = 1'b0;
      end else if (ex_tmo && ex_lost) begin
        ec_en_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_data_d.crank_nosig_enable   = ck_en_d;
    out_data_d.intake_nosig_enable  = ic_en_d;
    out_data_d.exhaust_nosig_enable = ec_en_d;
    if (in_data_i.action) begin
      out_data_d.crank_event   = EvNone;
      out_data_d.intake_event  = EvNone;
      out_data_d.exhaust_event = EvNone;
    end else begin
      out_data_d.crank_event = (ck_en_d || in_data_i.force_crank_test) ? EvNosig : EvLoss;
      if (intake_present_q) begin
        out_data_d.intake_event =
          (ic_en_d || in_data_i.force_intake_test) ? EvNosig : EvLoss;
      end else begin
        out_data_d.intake_event = in_data_i.force_intake_test ? EvNosig : EvNone;
      end
      if (exhaust_present_q) begin
        out_data_d.exhaust_event =
          (ec_en_d || in_data_i.force_exhaust_test) ? EvNosig : EvLoss;
      end else begin
        out_data_d.exhaust_event = in_data_i.force_exhaust_test ? EvNosig : EvNone;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ck_en_q     <= 1'b0;
      ic_en_q     <= 1'b0;
      ec_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        ck_en_q     <= ck_en_d;
        ic_en_q     <= ic_en_d;
        ec_en_q     <= ec_en_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

@@ hw/rtl/ccslm_checker.sv @@
// Port-level checker for the crank and cam signal-loss monitor, with its bind.
// Depends on ccslm_pkg and the top level crank_cam_signal_loss_monitor.
module ccslm_checker import ccslm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input ccslm_in_t  in_data_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input ccslm_out_t out_data_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  a_beat_yields_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> out_valid_o)
    else $error("accepted beat gave no result");

  a_key_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_data_i.action |=>
      out_data_o.crank_event == EvNone &&
      out_data_o.crank_nosig_enable == !$past(in_data_i.rotation_detected) &&
      out_data_o.exhaust_nosig_enable == !$past(in_data_i.rotation_detected))
    else $error("key-on result is wrong");

  a_crank_sync_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !in_data_i.action && in_data_i.crank_sync &&
      in_data_i.crank_sync_status && !in_data_i.force_crank_test |=>
      out_data_o.crank_event == EvLoss && !out_data_o.crank_nosig_enable)
    else $error("synchronized crank left its no-signal enable set");

  a_none_only_on_key_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.crank_event == EvNone |->
      out_data_o.intake_event == EvNone && out_data_o.exhaust_event == EvNone)
    else $error("crank event none outside a key-on result");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind crank_cam_signal_loss_monitor ccslm_checker u_ccslm_checker (.*);
